/* hdl/adc_ladder_key_debouncer_assert.svh */
// Assertion macros shared by the key decoder RTL.
`ifndef ADC_LADDER_KEY_DEBOUNCER_ASSERT_SVH
`define ADC_LADDER_KEY_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ALD_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ALD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/ald_pkg.sv */
// Package: constants, types and codes of the ladder key decoder.
package ald_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 8;

   localparam int SCALE_W = 12;
   localparam int FS_W    = 16;
   localparam int DEB_W   = 8;
   localparam int KEY_W   = 3;
   localparam int STAT_W  = 2;
   localparam int NUM_W   = SAMPLE_BITS + SCALE_W + 1;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int CMP_W   = (COUNT_BITS > DEB_W) ? COUNT_BITS : DEB_W;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(4095);

   localparam logic [FS_W-1:0]    FULL_SCALE_RST    = FS_W'(4095);
   localparam logic [DEB_W-1:0]   DEBOUNCE_RST      = DEB_W'(20);
   localparam logic [SCALE_W-1:0] THRESH_DOWN_RST   = SCALE_W'(515);
   localparam logic [SCALE_W-1:0] THRESH_UP_RST     = SCALE_W'(990);
   localparam logic [SCALE_W-1:0] THRESH_RIGHT_RST  = SCALE_W'(1457);
   localparam logic [SCALE_W-1:0] THRESH_LEFT_RST   = SCALE_W'(1935);
   localparam logic [SCALE_W-1:0] THRESH_CENTER_RST = SCALE_W'(2457);

   typedef enum logic [KEY_W-1:0] {
      KEY_NONE   = 3'd0,
      KEY_DOWN   = 3'd1,
      KEY_UP     = 3'd2,
      KEY_RIGHT  = 3'd3,
      KEY_LEFT   = 3'd4,
      KEY_CENTER = 3'd5
   } key_type;

   typedef enum logic [STAT_W-1:0] {
      ST_FREE         = 2'd0,
      ST_PRESSED      = 2'd1,
      ST_PRESS_EDGE   = 2'd2,
      ST_RELEASE_EDGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_FULL_SCALE    = 3'd0,
      REG_DEBOUNCE      = 3'd1,
      REG_THRESH_DOWN   = 3'd2,
      REG_THRESH_UP     = 3'd3,
      REG_THRESH_RIGHT  = 3'd4,
      REG_THRESH_LEFT   = 3'd5,
      REG_THRESH_CENTER = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_BIAS,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   typedef struct packed {
      logic [FS_W-1:0]    full_scale;
      logic [DEB_W-1:0]   debounce_ticks;
      logic [SCALE_W-1:0] thresh_down;
      logic [SCALE_W-1:0] thresh_up;
      logic [SCALE_W-1:0] thresh_right;
      logic [SCALE_W-1:0] thresh_left;
      logic [SCALE_W-1:0] thresh_center;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic sink_free;
   } div_ctrl_type;

   typedef struct packed {
      logic               idle;
      logic               done;
      logic [SCALE_W-1:0] quotient;
   } div_stat_type;

   typedef struct packed {
      key_type    current_key;
      key_type    last_pressed_key;
      status_type press_status;
   } key_out_type;

endpackage

/* hdl/ald_req_if.sv */
// Input channel: one raw converter sample per item.
interface ald_req_if;
   logic                          valid;
   logic                          ready;
   logic [ald_pkg::SAMPLE_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

/* hdl/ald_rsp_if.sv */
// Result channel: scaled value, keys and status per item.
interface ald_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ald_pkg::SCALE_W-1:0]   scaled_value;
   logic [ald_pkg::KEY_W-1:0]     current_key;
   logic [ald_pkg::KEY_W-1:0]     last_pressed_key;
   logic [ald_pkg::STAT_W-1:0]    press_status;

   modport source (output valid, output scaled_value, output current_key,
                   output last_pressed_key, output press_status, input ready);
   modport sink (input valid, input scaled_value, input current_key,
                 input last_pressed_key, input press_status, output ready);
endinterface

/* hdl/ald_csr.sv */
// APB-style register file holding the decoder configuration.
module ald_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ald_pkg::ADDR_W-1:0]   paddr,
   input  logic [ald_pkg::DATA_W-1:0]   pwdata,
   output logic [ald_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output ald_pkg::cfg_type             cfg
);

   ald_pkg::cfg_type       cfg_ff;
   ald_pkg::cfg_type       cfg_in;
   ald_pkg::reg_index_type index;
   logic                   wr_en;

   assign index  = ald_pkg::reg_index_type'(paddr[ald_pkg::ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            ald_pkg::REG_FULL_SCALE:    cfg_in.full_scale = pwdata[ald_pkg::FS_W-1:0];
            ald_pkg::REG_DEBOUNCE:      cfg_in.debounce_ticks = pwdata[ald_pkg::DEB_W-1:0];
            ald_pkg::REG_THRESH_DOWN:   cfg_in.thresh_down = pwdata[ald_pkg::SCALE_W-1:0];
            ald_pkg::REG_THRESH_UP:     cfg_in.thresh_up = pwdata[ald_pkg::SCALE_W-1:0];
            ald_pkg::REG_THRESH_RIGHT:  cfg_in.thresh_right = pwdata[ald_pkg::SCALE_W-1:0];
            ald_pkg::REG_THRESH_LEFT:   cfg_in.thresh_left = pwdata[ald_pkg::SCALE_W-1:0];
            ald_pkg::REG_THRESH_CENTER: cfg_in.thresh_center = pwdata[ald_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         ald_pkg::REG_FULL_SCALE:    prdata = ald_pkg::DATA_W'(cfg_ff.full_scale);
         ald_pkg::REG_DEBOUNCE:      prdata = ald_pkg::DATA_W'(cfg_ff.debounce_ticks);
         ald_pkg::REG_THRESH_DOWN:   prdata = ald_pkg::DATA_W'(cfg_ff.thresh_down);
         ald_pkg::REG_THRESH_UP:     prdata = ald_pkg::DATA_W'(cfg_ff.thresh_up);
         ald_pkg::REG_THRESH_RIGHT:  prdata = ald_pkg::DATA_W'(cfg_ff.thresh_right);
         ald_pkg::REG_THRESH_LEFT:   prdata = ald_pkg::DATA_W'(cfg_ff.thresh_left);
         ald_pkg::REG_THRESH_CENTER: prdata = ald_pkg::DATA_W'(cfg_ff.thresh_center);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale     <= ald_pkg::FULL_SCALE_RST;
         cfg_ff.debounce_ticks <= ald_pkg::DEBOUNCE_RST;
         cfg_ff.thresh_down    <= ald_pkg::THRESH_DOWN_RST;
         cfg_ff.thresh_up      <= ald_pkg::THRESH_UP_RST;
         cfg_ff.thresh_right   <= ald_pkg::THRESH_RIGHT_RST;
         cfg_ff.thresh_left    <= ald_pkg::THRESH_LEFT_RST;
         cfg_ff.thresh_center  <= ald_pkg::THRESH_CENTER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/ald_divider.sv */
// Bit-serial rescaler: (v*4095 + fs/2) / fs, saturated to 12 bits.
module ald_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  ald_pkg::div_ctrl_type             ctrl,
   input  logic [ald_pkg::SAMPLE_BITS-1:0]   sample,
   input  logic [ald_pkg::FS_W-1:0]          full_scale,
   output ald_pkg::div_stat_type             stat
);

   ald_pkg::div_state_type        state_ff, state_in;
   logic [ald_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [ald_pkg::FS_W-1:0]      fs_ff, fs_in;
   logic [ald_pkg::FS_W-1:0]      rem_ff, rem_in;
   logic [ald_pkg::SCALE_W-1:0]   q_ff, q_in;
   logic                          ovf_ff, ovf_in;
   logic [ald_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ald_pkg::FS_W:0]        trial;
   logic [ald_pkg::FS_W:0]        diff;
   logic                          ge;

   assign trial = {rem_ff, num_ff[ald_pkg::NUM_W-1]};
   assign ge    = trial >= {1'b0, fs_ff};
   assign diff  = trial - {1'b0, fs_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      fs_in    = fs_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      stat.idle     = 1'b0;
      stat.done     = 1'b0;
      stat.quotient = ovf_ff ? ald_pkg::SCALE_MAX : q_ff;
      case (state_ff)
         ald_pkg::DIV_IDLE: begin
            stat.idle = 1'b1;
            if (ctrl.start) begin
               num_in   = ald_pkg::NUM_W'(sample);
               fs_in    = (full_scale == '0) ? ald_pkg::FS_W'(ald_pkg::SCALE_MAX) : full_scale;
               state_in = ald_pkg::DIV_MUL;
            end
         end
         ald_pkg::DIV_MUL: begin
            // v*4095 as v*4096 - v
            num_in   = (num_ff << ald_pkg::SCALE_W) - num_ff;
            state_in = ald_pkg::DIV_BIAS;
         end
         ald_pkg::DIV_BIAS: begin
            num_in   = num_ff + ald_pkg::NUM_W'(fs_ff >> 1);
            rem_in   = '0;
            q_in     = '0;
            ovf_in   = 1'b0;
            cnt_in   = ald_pkg::CNT_W'(ald_pkg::NUM_W - 1);
            state_in = ald_pkg::DIV_RUN;
         end
         ald_pkg::DIV_RUN: begin
            rem_in = ge ? diff[ald_pkg::FS_W-1:0] : trial[ald_pkg::FS_W-1:0];
            num_in = num_ff << 1;
            q_in   = {q_ff[ald_pkg::SCALE_W-2:0], ge};
            ovf_in = ovf_ff | q_ff[ald_pkg::SCALE_W-1];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ald_pkg::DIV_HOLD;
            end
         end
         ald_pkg::DIV_HOLD: begin
            if (ctrl.sink_free) begin
               stat.done = 1'b1;
               state_in  = ald_pkg::DIV_IDLE;
            end
         end
         default: state_in = ald_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ald_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      fs_ff  <= fs_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* hdl/ald_debounce.sv */
// Threshold decode and debounce of the ladder key.
module ald_debounce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            update,
   input  logic [ald_pkg::SCALE_W-1:0]     scaled,
   input  ald_pkg::cfg_type                cfg,
   output ald_pkg::key_out_type            key_out
);

   ald_pkg::key_type                  cand;
   ald_pkg::key_type                  cand_ff, cand_in;
   ald_pkg::key_type                  acc_ff, acc_in;
   ald_pkg::key_type                  prev_ff, prev_in;
   logic [ald_pkg::COUNT_BITS-1:0]    stable_ff, stable_in;
   logic [ald_pkg::CMP_W-1:0]         deb_ext;
   logic                              settled;

   always_comb begin
      if (scaled < cfg.thresh_down) begin
         cand = ald_pkg::KEY_NONE;
      end else if (scaled < cfg.thresh_up) begin
         cand = ald_pkg::KEY_DOWN;
      end else if (scaled < cfg.thresh_right) begin
         cand = ald_pkg::KEY_UP;
      end else if (scaled < cfg.thresh_left) begin
         cand = ald_pkg::KEY_RIGHT;
      end else if (scaled < cfg.thresh_center) begin
         cand = ald_pkg::KEY_LEFT;
      end else begin
         cand = ald_pkg::KEY_CENTER;
      end
   end

   assign deb_ext = ald_pkg::CMP_W'(cfg.debounce_ticks);

   always_comb begin
      cand_in = cand;
      if (cand != cand_ff) begin
         stable_in = '0;
      end else if ((ald_pkg::CMP_W'(stable_ff) < deb_ext) && (stable_ff != '1)) begin
         stable_in = stable_ff + 1'b1;
      end else begin
         stable_in = stable_ff;
      end
      settled = ald_pkg::CMP_W'(stable_in) >= deb_ext;

      acc_in  = acc_ff;
      prev_in = prev_ff;
      key_out.press_status = (acc_ff == ald_pkg::KEY_NONE) ? ald_pkg::ST_FREE
                                                           : ald_pkg::ST_PRESSED;
      if (settled && (acc_ff != cand)) begin
         acc_in = cand;
         if (cand != ald_pkg::KEY_NONE) begin
            prev_in = cand;
         end
         if (acc_ff == ald_pkg::KEY_NONE && cand != ald_pkg::KEY_NONE) begin
            key_out.press_status = ald_pkg::ST_PRESS_EDGE;
         end else if (acc_ff != ald_pkg::KEY_NONE && cand == ald_pkg::KEY_NONE) begin
            key_out.press_status = ald_pkg::ST_RELEASE_EDGE;
         end else if (cand == ald_pkg::KEY_NONE) begin
            key_out.press_status = ald_pkg::ST_FREE;
         end else begin
            key_out.press_status = ald_pkg::ST_PRESSED;
         end
      end
      key_out.current_key      = acc_in;
      key_out.last_pressed_key = prev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= ald_pkg::KEY_NONE;
         acc_ff    <= ald_pkg::KEY_NONE;
         prev_ff   <= ald_pkg::KEY_NONE;
         stable_ff <= '0;
      end else if (update) begin
         cand_ff   <= cand_in;
         acc_ff    <= acc_in;
         prev_ff   <= prev_in;
         stable_ff <= stable_in;
      end
   end

endmodule

/* hdl/adc_ladder_key_debouncer.sv */
// Top level: five-way resistor-ladder key decoder with debounce.
//
// Usage:
//   req_chan carries one raw converter sample per item (valid/ready).
//   rsp_chan returns one item per sample: the sample rescaled to 12 bits,
//   the debounced key, the last pressed key and the key status.
//   Registers (full scale, debounce count, five thresholds) sit on the
//   APB-style port at byte address 4*i; write them only while idle.
// Processing:
//   An item is processed one at a time. The rescale divider retires one
//   numerator bit per cycle over SAMPLE_BITS+13 bits, after the multiply
//   and bias setup states and before the hold state that hands the result
//   off; a new sample is taken once the divider is back to idle.
// Reset: synchronous; registers return to their defaults, the debounce
//   state clears to no key and no result is pending.
// Stall: a result waits in the output register while the next sample is
//   taken and divided; the divider then holds its quotient until the
//   output register drains.
module adc_ladder_key_debouncer (
   input  logic                        clock,
   input  logic                        reset,
   ald_req_if.sink                     req_chan,
   ald_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ald_pkg::ADDR_W-1:0]  paddr,
   input  logic [ald_pkg::DATA_W-1:0]  pwdata,
   output logic [ald_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   `include "adc_ladder_key_debouncer_assert.svh"

   ald_pkg::cfg_type              cfg;
   ald_pkg::div_ctrl_type         div_ctrl;
   ald_pkg::div_stat_type         div_stat;
   ald_pkg::key_out_type          key_out;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ald_pkg::SCALE_W-1:0]   rsp_scaled_ff, rsp_scaled_in;
   ald_pkg::key_out_type          rsp_key_ff, rsp_key_in;

   ald_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_chan.ready = div_stat.idle;
   // start, sink_free
   assign div_ctrl       = {req_chan.valid & div_stat.idle, ~rsp_valid_ff | rsp_chan.ready};

   ald_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .sample     (req_chan.adc_sample),
      .full_scale (cfg.full_scale),
      .stat       (div_stat)
   );

   ald_debounce u_debounce (
      .clock   (clock),
      .reset   (reset),
      .update  (div_stat.done),
      .scaled  (div_stat.quotient),
      .cfg     (cfg),
      .key_out (key_out)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_key_in    = rsp_key_ff;
      if (div_stat.done) begin
         rsp_valid_in  = 1'b1;
         rsp_scaled_in = div_stat.quotient;
         rsp_key_in    = key_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.scaled_value     = rsp_scaled_ff;
   assign rsp_chan.current_key      = rsp_key_ff.current_key;
   assign rsp_chan.last_pressed_key = rsp_key_ff.last_pressed_key;
   assign rsp_chan.press_status     = rsp_key_ff.press_status;

   `ALD_ASSERT(a_load_only_when_free, div_stat.done, (!rsp_valid_ff || rsp_chan.ready))
   `ALD_ASSERT_NEXT(a_done_gives_item, div_stat.done, rsp_valid_ff)
   `ALD_ASSERT(a_press_edge_has_key, (rsp_valid_ff && rsp_key_ff.press_status == ald_pkg::ST_PRESS_EDGE), (rsp_key_ff.current_key != ald_pkg::KEY_NONE))
   `ALD_ASSERT(a_last_tracks_current, (rsp_valid_ff && rsp_key_ff.current_key != ald_pkg::KEY_NONE), (rsp_key_ff.last_pressed_key == rsp_key_ff.current_key))

endmodule

/* dv/tb_adc_ladder_key_debouncer.sv */
`timescale 1ns / 1ps
// Testbench for the ladder key decoder: directed table, then random phases checked by a predictor.
module tb_adc_ladder_key_debouncer;

   localparam int LIMIT_CYCLES  = 500_000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam logic [ald_pkg::COUNT_BITS-1:0] STABLE_MAX = '1;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_op_type;

   typedef struct packed {
      logic [ald_pkg::SCALE_W-1:0] scaled_value;
      ald_pkg::key_type            current_key;
      ald_pkg::key_type            last_pressed_key;
      ald_pkg::status_type         press_status;
   } key_reading_type;

   typedef struct {
      row_op_type      op;
      logic [2:0]      reg_idx;
      logic [31:0]     value;
      bit              typed;
      key_reading_type reading;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ald_pkg::ADDR_W-1:0] paddr;
   logic [ald_pkg::DATA_W-1:0] pwdata;
   logic [ald_pkg::DATA_W-1:0] prdata;
   logic pready;

   ald_req_if req_chan();
   ald_rsp_if rsp_chan();

   ald_pkg::cfg_type               model_cfg;
   ald_pkg::key_type               cand_key;
   ald_pkg::key_type               held_key;
   ald_pkg::key_type               last_pressed;
   logic [ald_pkg::COUNT_BITS-1:0] steady_ticks;

   key_reading_type expected_readings[$];
   stim_row_type    directed_rows[$];
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int fail_count         = 0;
   int cycle_count        = 0;

   adc_ladder_key_debouncer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void reset_key_model();
      model_cfg.full_scale     = ald_pkg::FULL_SCALE_RST;
      model_cfg.debounce_ticks = ald_pkg::DEBOUNCE_RST;
      model_cfg.thresh_down    = ald_pkg::THRESH_DOWN_RST;
      model_cfg.thresh_up      = ald_pkg::THRESH_UP_RST;
      model_cfg.thresh_right   = ald_pkg::THRESH_RIGHT_RST;
      model_cfg.thresh_left    = ald_pkg::THRESH_LEFT_RST;
      model_cfg.thresh_center  = ald_pkg::THRESH_CENTER_RST;
      cand_key     = ald_pkg::KEY_NONE;
      held_key     = ald_pkg::KEY_NONE;
      last_pressed = ald_pkg::KEY_NONE;
      steady_ticks = '0;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
         ald_pkg::REG_FULL_SCALE:    model_cfg.full_scale     = data[ald_pkg::FS_W-1:0];
         ald_pkg::REG_DEBOUNCE:      model_cfg.debounce_ticks = data[ald_pkg::DEB_W-1:0];
         ald_pkg::REG_THRESH_DOWN:   model_cfg.thresh_down    = data[ald_pkg::SCALE_W-1:0];
         ald_pkg::REG_THRESH_UP:     model_cfg.thresh_up      = data[ald_pkg::SCALE_W-1:0];
         ald_pkg::REG_THRESH_RIGHT:  model_cfg.thresh_right   = data[ald_pkg::SCALE_W-1:0];
         ald_pkg::REG_THRESH_LEFT:   model_cfg.thresh_left    = data[ald_pkg::SCALE_W-1:0];
         ald_pkg::REG_THRESH_CENTER: model_cfg.thresh_center  = data[ald_pkg::SCALE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [ald_pkg::SCALE_W-1:0] rescale_sample(
         logic [ald_pkg::SAMPLE_BITS-1:0] v);
      logic [63:0] fs;
      logic [63:0] q;
      fs = (model_cfg.full_scale == '0) ? 64'(ald_pkg::SCALE_MAX)
                                        : 64'(model_cfg.full_scale);
      q  = (64'(v) * 64'(ald_pkg::SCALE_MAX) + fs / 2) / fs;
      return (q > 64'(ald_pkg::SCALE_MAX)) ? ald_pkg::SCALE_MAX : q[ald_pkg::SCALE_W-1:0];
   endfunction

   function automatic ald_pkg::key_type classify_level(logic [ald_pkg::SCALE_W-1:0] s);
      if (s < model_cfg.thresh_down) return ald_pkg::KEY_NONE;
      if (s < model_cfg.thresh_up) return ald_pkg::KEY_DOWN;
      if (s < model_cfg.thresh_right) return ald_pkg::KEY_UP;
      if (s < model_cfg.thresh_left) return ald_pkg::KEY_RIGHT;
      if (s < model_cfg.thresh_center) return ald_pkg::KEY_LEFT;
      return ald_pkg::KEY_CENTER;
   endfunction

   function automatic key_reading_type predict_reading(logic [ald_pkg::SAMPLE_BITS-1:0] v);
      key_reading_type     r;
      ald_pkg::key_type    cand;
      ald_pkg::key_type    prior;
      ald_pkg::status_type st;
      r.scaled_value = rescale_sample(v);
      cand = classify_level(r.scaled_value);
      if (cand != cand_key) begin
         cand_key     = cand;
         steady_ticks = '0;
      end else if (steady_ticks < model_cfg.debounce_ticks && steady_ticks < STABLE_MAX) begin
         steady_ticks = steady_ticks + 1'b1;
      end
      if (steady_ticks >= model_cfg.debounce_ticks && held_key != cand_key) begin
         prior    = held_key;
         held_key = cand_key;
         if (held_key != ald_pkg::KEY_NONE) last_pressed = held_key;
         if (prior == ald_pkg::KEY_NONE && held_key != ald_pkg::KEY_NONE)
            st = ald_pkg::ST_PRESS_EDGE;
         else if (prior != ald_pkg::KEY_NONE && held_key == ald_pkg::KEY_NONE)
            st = ald_pkg::ST_RELEASE_EDGE;
         else if (held_key == ald_pkg::KEY_NONE)
            st = ald_pkg::ST_FREE;
         else
            st = ald_pkg::ST_PRESSED;
      end else begin
         st = (held_key == ald_pkg::KEY_NONE) ? ald_pkg::ST_FREE : ald_pkg::ST_PRESSED;
      end
      r.current_key      = held_key;
      r.last_pressed_key = last_pressed;
      r.press_status     = st;
      return r;
   endfunction

   function automatic void add_sample(logic [15:0] v);
      stim_row_type row;
      row.op      = ROW_SAMPLE;
      row.reg_idx = '0;
      row.value   = 32'(v);
      row.typed   = 1'b0;
      row.reading = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(logic [15:0] v, logic [ald_pkg::SCALE_W-1:0] s,
                                     ald_pkg::key_type cur, ald_pkg::key_type last,
                                     ald_pkg::status_type st);
      stim_row_type row;
      row.op                       = ROW_SAMPLE;
      row.reg_idx                  = '0;
      row.value                    = 32'(v);
      row.typed                    = 1'b1;
      row.reading.scaled_value     = s;
      row.reading.current_key      = cur;
      row.reading.last_pressed_key = last;
      row.reading.press_status     = st;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [2:0] idx, logic [31:0] value);
      stim_row_type row;
      row.op      = ROW_WRITE;
      row.reg_idx = idx;
      row.value   = value;
      row.typed   = 1'b0;
      row.reading = '0;
      directed_rows.push_back(row);
   endfunction

   // junk above the register width must be ignored
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] data;
      data = $urandom();
      case (idx)
         ald_pkg::REG_FULL_SCALE: data[ald_pkg::FS_W-1:0]  = value[ald_pkg::FS_W-1:0];
         ald_pkg::REG_DEBOUNCE:   data[ald_pkg::DEB_W-1:0] = value[ald_pkg::DEB_W-1:0];
         default:                 data[ald_pkg::SCALE_W-1:0] = value[ald_pkg::SCALE_W-1:0];
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      apply_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic drive_sample(input logic [15:0] v, input bit typed,
                               input key_reading_type typed_reading);
      key_reading_type predicted;
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.adc_sample <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_reading(v);
      expected_readings.push_back(typed ? typed_reading : predicted);
   endtask

   always @(posedge clock) begin : result_checker
      key_reading_type exp;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected result item: scaled_value %0d", rsp_chan.scaled_value);
               fail_count++;
            end else begin
               exp = expected_readings.pop_front();
               if (rsp_chan.scaled_value !== exp.scaled_value) begin
                  $error("scaled_value: expected %0d, got %0d",
                         exp.scaled_value, rsp_chan.scaled_value);
                  fail_count++;
               end
               if (rsp_chan.current_key !== exp.current_key) begin
                  $error("current_key: expected %0d, got %0d",
                         exp.current_key, rsp_chan.current_key);
                  fail_count++;
               end
               if (rsp_chan.last_pressed_key !== exp.last_pressed_key) begin
                  $error("last_pressed_key: expected %0d, got %0d",
                         exp.last_pressed_key, rsp_chan.last_pressed_key);
                  fail_count++;
               end
               if (rsp_chan.press_status !== exp.press_status) begin
                  $error("press_status: expected %0d, got %0d",
                         exp.press_status, rsp_chan.press_status);
                  fail_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin : stimulus
      logic [15:0] fs_value;
      logic [15:0] base;
      logic [15:0] sample;
      logic [11:0] th[5];
      int deb;
      int fs_eff;
      int acc;
      int items;
      int sent;
      int run_len;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.adc_sample <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      reset_key_model();

      add_typed(16'd0, 12'd0, ald_pkg::KEY_NONE, ald_pkg::KEY_NONE, ald_pkg::ST_FREE);
      add_typed(16'hFFFF, ald_pkg::SCALE_MAX, ald_pkg::KEY_NONE, ald_pkg::KEY_NONE,
                ald_pkg::ST_FREE);
      add_typed(16'd4095, ald_pkg::SCALE_MAX, ald_pkg::KEY_NONE, ald_pkg::KEY_NONE,
                ald_pkg::ST_FREE);
      add_write(ald_pkg::REG_DEBOUNCE, 32'd0);
      add_write(REG_UNUSED, 32'hFFFF_FFFF);
      add_typed(16'd515, 12'd515, ald_pkg::KEY_DOWN, ald_pkg::KEY_DOWN,
                ald_pkg::ST_PRESS_EDGE);
      add_typed(16'd514, 12'd514, ald_pkg::KEY_NONE, ald_pkg::KEY_DOWN,
                ald_pkg::ST_RELEASE_EDGE);
      add_typed(16'd990, 12'd990, ald_pkg::KEY_UP, ald_pkg::KEY_UP, ald_pkg::ST_PRESS_EDGE);
      add_typed(16'd1457, 12'd1457, ald_pkg::KEY_RIGHT, ald_pkg::KEY_RIGHT,
                ald_pkg::ST_PRESSED);
      add_typed(16'd1935, 12'd1935, ald_pkg::KEY_LEFT, ald_pkg::KEY_LEFT,
                ald_pkg::ST_PRESSED);
      add_typed(16'd2457, 12'd2457, ald_pkg::KEY_CENTER, ald_pkg::KEY_CENTER,
                ald_pkg::ST_PRESSED);
      add_typed(16'd2457, 12'd2457, ald_pkg::KEY_CENTER, ald_pkg::KEY_CENTER,
                ald_pkg::ST_PRESSED);
      add_typed(16'd2456, 12'd2456, ald_pkg::KEY_LEFT, ald_pkg::KEY_LEFT,
                ald_pkg::ST_PRESSED);
      add_typed(16'd0, 12'd0, ald_pkg::KEY_NONE, ald_pkg::KEY_LEFT, ald_pkg::ST_RELEASE_EDGE);
      add_typed(16'd0, 12'd0, ald_pkg::KEY_NONE, ald_pkg::KEY_LEFT, ald_pkg::ST_FREE);
      add_write(ald_pkg::REG_FULL_SCALE, 32'd0);
      add_sample(16'd2000);
      add_sample(16'hFFFF);
      add_write(ald_pkg::REG_FULL_SCALE, 32'hFFFF);
      add_sample(16'hFFFF);
      add_sample(16'd1);
      add_sample(16'h8000);
      add_write(ald_pkg::REG_FULL_SCALE, 32'd1);
      add_sample(16'd1);
      add_sample(16'd2);
      // thresholds out of order
      add_write(ald_pkg::REG_FULL_SCALE, 32'd4095);
      add_write(ald_pkg::REG_THRESH_DOWN, 32'd2000);
      add_write(ald_pkg::REG_THRESH_UP, 32'd1000);
      add_write(ald_pkg::REG_THRESH_RIGHT, 32'd4095);
      add_write(ald_pkg::REG_THRESH_LEFT, 32'd0);
      add_write(ald_pkg::REG_THRESH_CENTER, 32'd0);
      add_sample(16'd1500);
      add_sample(16'd3000);
      add_sample(16'd4095);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_WRITE) begin
            drain_results();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
         end else begin
            drive_sample(directed_rows[i].value[15:0], directed_rows[i].typed,
                         directed_rows[i].reading);
         end
      end

      for (int p = 0; p < 6; p++) begin
         drain_results();
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
            default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         endcase
         case (p)
            1: fs_value = 16'd0;
            2: fs_value = 16'hFFFF;
            4: fs_value = 16'($urandom_range(1, 65535));
            5: fs_value = 16'($urandom_range(1, 300));
            default: fs_value = 16'd4095;
         endcase
         case (p)
            1: deb = 0;
            3: deb = 255;
            default: deb = $urandom_range(1, 8);
         endcase
         if (p == 4) begin
            foreach (th[j]) th[j] = 12'($urandom_range(4095));
         end else if (p == 5) begin
            th[0] = 12'd0;
            th[1] = 12'd4095;
            th[2] = 12'd0;
            th[3] = 12'd4095;
            th[4] = 12'd4095;
         end else begin
            acc = 0;
            foreach (th[j]) begin
               acc = acc + $urandom_range(1, 800);
               th[j] = (acc > 4095) ? 12'd4095 : 12'(acc);
            end
         end
         write_reg(ald_pkg::REG_FULL_SCALE, 32'(fs_value));
         write_reg(ald_pkg::REG_DEBOUNCE, 32'(deb));
         write_reg(ald_pkg::REG_THRESH_DOWN, 32'(th[0]));
         write_reg(ald_pkg::REG_THRESH_UP, 32'(th[1]));
         write_reg(ald_pkg::REG_THRESH_RIGHT, 32'(th[2]));
         write_reg(ald_pkg::REG_THRESH_LEFT, 32'(th[3]));
         write_reg(ald_pkg::REG_THRESH_CENTER, 32'(th[4]));

         fs_eff = (fs_value == 16'd0) ? 4095 : int'(fs_value);
         items  = (p == 3) ? 320 : 116;
         sent   = 0;
         while (sent < items) begin
            // held key: a steady sample aimed at a scaled value, with the odd glitch
            if ($urandom_range(99) < 75) base = 16'($urandom_range(4095) * fs_eff / 4095);
            else base = 16'($urandom_range(65535));
            run_len = (deb > 32) ? $urandom_range(deb - 10, deb + 20) : $urandom_range(1, deb + 6);
            for (int k = 0; k < run_len && sent < items; k++) begin
               if (sent == items / 2) drain_results();
               sample = ($urandom_range(99) < 8) ? 16'($urandom()) : base;
               drive_sample(sample, 1'b0, '0);
               sent++;
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/ald_pkg.sv
hdl/ald_req_if.sv
hdl/ald_rsp_if.sv
hdl/ald_csr.sv
hdl/ald_divider.sv
hdl/ald_debounce.sv
hdl/adc_ladder_key_debouncer.sv
dv/tb_adc_ladder_key_debouncer.sv
